>>> rtl/core/kmna_pkg.sv
// ----------------------------------------------------------------------------
// kmna_pkg
// Types and constants shared by the nearest-mode assignment block.
// ----------------------------------------------------------------------------
package kmna_pkg;

  localparam int CAT_W     = 8;
  localparam int NUM_CATS  = 8;
  localparam int VEC_W     = CAT_W * NUM_CATS;
  localparam int IDX_W     = 4;
  localparam int COST_W    = 4;
  localparam int LANES     = 16;
  localparam int KEY_W     = COST_W + 1;
  localparam int CFG_CAT_W = 4;
  localparam int CFG_CLU_W = 5;
  localparam int CFG_W     = 5;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_CATEGORY_COUNT = 1'b0,
    REG_CLUSTER_COUNT  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] mode_index;
    logic [VEC_W-1:0] vector;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cluster_index;
    logic [COST_W-1:0] mismatch_cost;
  } result_t;

  // A search candidate. The top bit of key marks a lane that does not take
  // part, so it always loses against an active lane.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
  } cand_t;

  // Keeps a unless b is strictly better; a always carries the lower index.
  function automatic cand_t cand_pick(cand_t a, cand_t b);
    cand_t r;
    r = (b.key < a.key) ? b : a;
    return r;
  endfunction

endpackage

>>> rtl/core/kmna_argmin.sv
// ----------------------------------------------------------------------------
// kmna_argmin
// Two-stage registered minimum search over the per-cluster costs.
// ----------------------------------------------------------------------------
module kmna_argmin (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  kmna_pkg::cand_t [kmna_pkg::LANES-1:0] cands,
  output logic                                  out_valid,
  output kmna_pkg::result_t                     result
);
  import kmna_pkg::*;

  localparam int MID = LANES / 4;

  cand_t [MID-1:0] mid_next;
  cand_t [MID-1:0] mid;
  logic            mid_valid;
  cand_t           best_next;

  // First stage: each group of four lanes is reduced to one candidate.
  always_comb begin
    for (int g = 0; g < MID; g++) begin
      mid_next[g] = cand_pick(cand_pick(cands[4*g], cands[4*g+1]),
                              cand_pick(cands[4*g+2], cands[4*g+3]));
    end
  end

  always_comb begin
    best_next = cand_pick(cand_pick(mid[0], mid[1]), cand_pick(mid[2], mid[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid                  <= mid_next;
    result.cluster_index <= best_next.index;
    result.mismatch_cost <= best_next.key[COST_W-1:0];
  end

endmodule

>>> rtl/core/kmodes_nearest_mode_assign.sv
// ----------------------------------------------------------------------------
// kmodes_nearest_mode_assign
// Timing: a classify request is registered in s1, then in the s2 candidates,
// the argmin mid stage and the result, which done marks; a mode write gives
// no result and lands in the table at once. Throughput: one request per
// cycle while busy is low; the receiver cannot stall the pipeline.
// Reset: busy is high during reset and for the cycle after; the mode table is
// not cleared and must be written before it is classified against.
// ----------------------------------------------------------------------------
module kmodes_nearest_mode_assign #(
  parameter int MAX_CATEGORIES = 8,
  parameter int MAX_CLUSTERS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  kmna_pkg::req_t              req,
  output logic                        done,
  output kmna_pkg::result_t           result,
  input  logic                        cfg_wr,
  input  logic                        cfg_addr,
  input  logic [kmna_pkg::CFG_W-1:0]  cfg_data
);
  import kmna_pkg::*;

  localparam int DEPTH = (MAX_CLUSTERS < LANES) ? MAX_CLUSTERS : LANES;
  localparam int CATS  = (MAX_CATEGORIES < NUM_CATS) ? MAX_CATEGORIES : NUM_CATS;

  logic [CFG_CAT_W-1:0] category_count;
  logic [CFG_CLU_W-1:0] cluster_count;
  logic [CFG_CAT_W-1:0] cats_eff;
  logic [CFG_CLU_W-1:0] clus_eff;
  logic [NUM_CATS-1:0]  cat_mask;
  logic [LANES-1:0]     lane_active;

  logic                 accept;
  logic [VEC_W-1:0]     mode_table [DEPTH];

  logic                 s1_valid;
  logic [VEC_W-1:0]     s1_vec;
  logic                 s2_valid;
  cand_t [LANES-1:0]    s2_cand;
  cand_t [LANES-1:0]    s2_cand_next;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      category_count <= CFG_CAT_W'(NUM_CATS);
      cluster_count  <= CFG_CLU_W'(LANES);
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_CATEGORY_COUNT: category_count <= cfg_data[CFG_CAT_W-1:0];
        REG_CLUSTER_COUNT:  cluster_count  <= cfg_data[CFG_CLU_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clamped; a cluster count of zero
  // still lets mode zero take part.
  always_comb begin
    cats_eff = (category_count > CFG_CAT_W'(CATS)) ? CFG_CAT_W'(CATS) : category_count;
    if (cluster_count == '0) begin
      clus_eff = CFG_CLU_W'(1);
    end else if (cluster_count > CFG_CLU_W'(DEPTH)) begin
      clus_eff = CFG_CLU_W'(DEPTH);
    end else begin
      clus_eff = cluster_count;
    end
    for (int c = 0; c < NUM_CATS; c++) begin
      cat_mask[c] = CFG_CAT_W'(c) < cats_eff;
    end
    for (int l = 0; l < LANES; l++) begin
      lane_active[l] = (l < DEPTH) && (CFG_CLU_W'(l) < clus_eff);
    end
  end

  // Writes to an index beyond the table are dropped.
  always_ff @(posedge clk) begin
    if (accept && req.opcode == OP_WRITE &&
        {1'b0, req.mode_index} < (IDX_W + 1)'(DEPTH)) begin
      mode_table[req.mode_index[$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]] <= req.vector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && req.opcode == OP_CLASSIFY;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_vec  <= req.vector;
    s2_cand <= s2_cand_next;
  end

  // Per-lane Hamming distance over the active category bytes.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l < DEPTH) begin : g_used
      logic [NUM_CATS-1:0] diff;
      logic [COST_W-1:0]   cost;
      always_comb begin
        cost = '0;
        for (int c = 0; c < NUM_CATS; c++) begin
          diff[c] = cat_mask[c] &&
                    (s1_vec[c*CAT_W +: CAT_W] != mode_table[l][c*CAT_W +: CAT_W]);
          cost = cost + COST_W'(diff[c]);
        end
        s2_cand_next[l].key   = {!lane_active[l], cost};
        s2_cand_next[l].index = IDX_W'(l);
      end
    end else begin : g_unused
      always_comb begin
        s2_cand_next[l].key   = {1'b1, {COST_W{1'b0}}};
        s2_cand_next[l].index = IDX_W'(l);
      end
    end
  end

  kmna_argmin u_argmin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .cands     (s2_cand),
    .out_valid (done),
    .result    (result)
  );

endmodule
